FILE: hdl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants of the tone pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

   localparam int HZ_W   = 16;
   localparam int MS_W   = 16;
   localparam int REP_W  = 8;
   localparam int DUTY_W = 7;
   localparam int CLK_W  = 27;
   localparam int PER_W  = HZ_W + 1;
   localparam int PROD_W = PER_W + DUTY_W;
   localparam int OP_W   = 3;
   localparam int PH_W   = 2;
   localparam int CSR_IDX_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
   localparam logic [OP_W-1:0] OP_PATTERN    = 3'd1;
   localparam logic [OP_W-1:0] OP_ONCE       = 3'd2;
   localparam logic [OP_W-1:0] OP_HOLD_START = 3'd3;
   localparam logic [OP_W-1:0] OP_HOLD_STOP  = 3'd4;
   localparam logic [OP_W-1:0] OP_STOP_ALL   = 3'd5;

   // pattern machine phases
   localparam logic [PH_W-1:0] PH_IDLE = 2'd0;
   localparam logic [PH_W-1:0] PH_ON   = 2'd1;
   localparam logic [PH_W-1:0] PH_OFF  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HZ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HZ = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLK_HZ = 2'd2;

   localparam logic [HZ_W-1:0]  MIN_HZ_RST = 16'd100;
   localparam logic [HZ_W-1:0]  MAX_HZ_RST = 16'd10000;
   localparam logic [CLK_W-1:0] CLK_HZ_RST = 27'd1000000;

   localparam logic [DUTY_W-1:0] DUTY_MIN   = 7'd1;
   localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd99;
   localparam logic [HZ_W-1:0]   PCT_DIV    = 16'd100;
   localparam logic [HZ_W-1:0]   RELOAD_MAX = 16'hFFFF;

   typedef struct packed {
      logic [HZ_W-1:0]   hz;
      logic [MS_W-1:0]   on_ms;
      logic [MS_W-1:0]   off_ms;
      logic [REP_W-1:0]  rep_count;
      logic [DUTY_W-1:0] duty;
   } pattern_type;

   typedef struct packed {
      logic [HZ_W-1:0]   hz;
      logic [DUTY_W-1:0] duty;
   } tone_req_type;

   typedef struct packed {
      logic [HZ_W-1:0]  min_hz;
      logic [HZ_W-1:0]  max_hz;
      logic [CLK_W-1:0] clk_hz;
   } tone_cfg_type;

endpackage

`default_nettype wire

FILE: hdl/tone_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// tone_pattern_sequencer_top
// Buzzer tone sequencer: pattern queue, 1 ms phase machine, PWM setup.
// ----------------------------------------------------------------------------
// One request word carries one command (tick, queue pattern, queue single
// tone, hold start, hold stop, stop all) and yields exactly one response word
// with the PWM enable, reload and compare values, busy flag, free queue
// slots and pattern phase as they stand after the command. Requests are taken
// one at a time; a response may wait on rsp_ready while the next request is
// already accepted. A command that starts no tone goes from execution
// straight to the response. A command that starts a tone (hold start, or a
// tick that begins a repetition) waits for the tone unit: its bit-serial
// divider (one quotient bit per cycle) forms clk/hz unless the clamped hz is
// zero; then a shift-add multiply and a second divide give period*duty/100.
// The queue is a RAM of QUEUE_DEPTH slots holding up to QUEUE_DEPTH-1
// patterns; stop all empties it by resetting its pointers. CSR writes
// (min_hz, max_hz, timer_clk_hz) land on the next edge with no gating; make
// them only while no request or response word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_pattern_sequencer_top #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [tps_pkg::OP_W-1:0]        req_operation,
   input  wire logic [tps_pkg::HZ_W-1:0]        req_tone_hz,
   input  wire logic [tps_pkg::MS_W-1:0]        req_on_time_ms,
   input  wire logic [tps_pkg::MS_W-1:0]        req_off_time_ms,
   input  wire logic [tps_pkg::REP_W-1:0]       req_repeat_count,
   input  wire logic [tps_pkg::DUTY_W-1:0]      req_duty_percent,
   // response channel
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic                            rsp_accepted,
   output      logic                            rsp_pwm_enable,
   output      logic [tps_pkg::HZ_W-1:0]        rsp_reload_value,
   output      logic [tps_pkg::HZ_W-1:0]        rsp_compare_value,
   output      logic                            rsp_busy_res,
   output      logic [2:0]                      rsp_queue_free,
   output      logic [tps_pkg::PH_W-1:0]        rsp_phase,
   // configuration
   input  wire logic                            csr_write_en,
   input  wire logic [tps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tps_pkg::CLK_W-1:0]       csr_wdata
);

   import tps_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = PW + 1;
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_TONE = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   // control state
   logic [1:0]      state_ff, state_in;
   logic [PW-1:0]   head_ff, head_in;
   logic [PW-1:0]   tail_ff, tail_in;
   logic [PH_W-1:0] phase_ff, phase_in;
   logic [MS_W-1:0] rem_ff, rem_in;
   pattern_type     cur_ff, cur_in;
   logic            hold_ff, hold_in;
   logic            pwm_ff, pwm_in;
   logic [HZ_W-1:0] reload_ff, reload_in;
   logic [HZ_W-1:0] compare_ff, compare_in;
   logic            acc_ff, acc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   tone_cfg_type    cfg_ff, cfg_in;

   // latched request word
   logic [OP_W-1:0] op_ff;
   pattern_type     item_ff;

   // response word
   logic            rsp_acc_ff, rsp_pwm_ff, rsp_busy_ff;
   logic [HZ_W-1:0] rsp_reload_ff, rsp_compare_ff;
   logic [2:0]      rsp_free_ff;
   logic [PH_W-1:0] rsp_phase_ff;
   logic            rsp_load;

   // queue RAM
   logic            push;
   pattern_type     push_data;
   pattern_type     rd_data;

   // tone unit
   logic            tone_go;
   tone_req_type    tone_req;
   logic            tone_done;
   logic [HZ_W-1:0] tone_reload, tone_compare;

   // queue bookkeeping
   logic [PW-1:0]   head_nx, tail_nx;
   logic            q_empty, q_full;
   logic [CW-1:0]   used, free_cnt;
   logic [CW+2:0]   free_ext;
   logic [MS_W-1:0] rem_dec;
   logic [REP_W-1:0] rep_dec;

   assign head_nx  = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign tail_nx  = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign q_empty  = (head_ff == tail_ff);
   assign q_full   = (head_nx == tail_ff);
   assign used     = (head_ff >= tail_ff) ? ({1'b0, head_ff} - {1'b0, tail_ff})
                   : (CW'(QUEUE_DEPTH) - {1'b0, tail_ff} + {1'b0, head_ff});
   assign free_cnt = CW'(QUEUE_DEPTH - 1) - used;
   assign free_ext = {3'b000, free_cnt};
   assign rem_dec  = (rem_ff != '0) ? rem_ff - 1'b1 : '0;
   assign rep_dec  = (cur_ff.rep_count != '0) ? cur_ff.rep_count - 1'b1 : '0;

   tps_ram #(
      .WIDTH ($bits(pattern_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (head_ff),
      .wr_data (push_data),
      .rd_addr (tail_ff),
      .rd_data (rd_data)
   );

   tps_tone u_tone (
      .clock   (clock),
      .reset   (reset),
      .start   (tone_go),
      .req     (tone_req),
      .cfg     (cfg_ff),
      .done    (tone_done),
      .reload  (tone_reload),
      .compare (tone_compare)
   );

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MIN_HZ: cfg_in.min_hz = csr_wdata[HZ_W-1:0];
            CSR_MAX_HZ: cfg_in.max_hz = csr_wdata[HZ_W-1:0];
            CSR_CLK_HZ: cfg_in.clk_hz = csr_wdata;
            default: ;
         endcase
      end
   end

   // command execution
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      phase_in     = phase_ff;
      rem_in       = rem_ff;
      cur_in       = cur_ff;
      hold_in      = hold_ff;
      pwm_in       = pwm_ff;
      reload_in    = reload_ff;
      compare_in   = compare_ff;
      acc_in       = acc_ff;
      push         = 1'b0;
      push_data    = item_ff;
      tone_go      = 1'b0;
      tone_req     = '{hz: cur_ff.hz, duty: cur_ff.duty};
      rsp_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            acc_in = 1'b1;
            unique case (op_ff)
               OP_TICK: begin
                  // held tone freezes the pattern machine
                  if (!hold_ff) begin
                     unique case (phase_ff)
                        PH_IDLE: begin
                           if (q_empty) begin
                              pwm_in = 1'b0;
                           end else begin
                              cur_in   = rd_data;
                              tail_in  = tail_nx;
                              rem_in   = rd_data.on_ms;
                              phase_in = PH_ON;
                              tone_go  = 1'b1;
                              tone_req = '{hz: rd_data.hz, duty: rd_data.duty};
                           end
                        end
                        PH_ON: begin
                           if (rem_dec == '0) begin
                              pwm_in   = 1'b0;
                              rem_in   = cur_ff.off_ms;
                              phase_in = PH_OFF;
                              if (cur_ff.off_ms == '0) begin
                                 // no gap: next repetition or finish now
                                 cur_in.rep_count = rep_dec;
                                 if (rep_dec != '0) begin
                                    tone_go  = 1'b1;
                                    rem_in   = cur_ff.on_ms;
                                    phase_in = PH_ON;
                                 end else begin
                                    phase_in = PH_IDLE;
                                 end
                              end
                           end else begin
                              rem_in = rem_dec;
                           end
                        end
                        default: begin
                           rem_in = rem_dec;
                           if (rem_dec == '0) begin
                              cur_in.rep_count = rep_dec;
                              if (rep_dec != '0) begin
                                 tone_go  = 1'b1;
                                 rem_in   = cur_ff.on_ms;
                                 phase_in = PH_ON;
                              end else begin
                                 phase_in = PH_IDLE;
                              end
                           end
                        end
                     endcase
                  end
               end
               OP_PATTERN: begin
                  if (item_ff.rep_count != '0) begin
                     if (q_full) begin
                        acc_in = 1'b0;
                     end else begin
                        push    = 1'b1;
                        head_in = head_nx;
                     end
                  end
               end
               OP_ONCE: begin
                  // single tone: no gap, one repetition
                  push_data.off_ms    = '0;
                  push_data.rep_count = REP_W'(1);
                  if (item_ff.on_ms != '0) begin
                     if (q_full) begin
                        acc_in = 1'b0;
                     end else begin
                        push    = 1'b1;
                        head_in = head_nx;
                     end
                  end
               end
               OP_HOLD_START: begin
                  hold_in  = 1'b1;
                  tone_go  = 1'b1;
                  tone_req = '{hz: item_ff.hz, duty: item_ff.duty};
               end
               OP_HOLD_STOP: begin
                  hold_in = 1'b0;
                  pwm_in  = 1'b0;
               end
               OP_STOP_ALL: begin
                  phase_in = PH_IDLE;
                  rem_in   = '0;
                  head_in  = '0;
                  tail_in  = '0;
                  hold_in  = 1'b0;
                  pwm_in   = 1'b0;
               end
               default: ;
            endcase
            state_in = tone_go ? S_TONE : S_DONE;
         end
         S_TONE: begin
            if (tone_done) begin
               reload_in  = tone_reload;
               compare_in = tone_compare;
               pwm_in     = 1'b1;
               state_in   = S_DONE;
            end
         end
         default: begin
            // S_DONE: hand the word over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase

      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         phase_ff     <= PH_IDLE;
         rem_ff       <= '0;
         cur_ff       <= '0;
         hold_ff      <= 1'b0;
         pwm_ff       <= 1'b0;
         reload_ff    <= '0;
         compare_ff   <= '0;
         acc_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{min_hz: MIN_HZ_RST, max_hz: MAX_HZ_RST, clk_hz: CLK_HZ_RST};
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         phase_ff     <= phase_in;
         rem_ff       <= rem_in;
         cur_ff       <= cur_in;
         hold_ff      <= hold_in;
         pwm_ff       <= pwm_in;
         reload_ff    <= reload_in;
         compare_ff   <= compare_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff             <= req_operation;
         item_ff.hz        <= req_tone_hz;
         item_ff.on_ms     <= req_on_time_ms;
         item_ff.off_ms    <= req_off_time_ms;
         item_ff.rep_count <= req_repeat_count;
         item_ff.duty      <= req_duty_percent;
      end
      if (rsp_load) begin
         rsp_acc_ff     <= acc_ff;
         rsp_pwm_ff     <= pwm_ff;
         rsp_reload_ff  <= reload_ff;
         rsp_compare_ff <= compare_ff;
         rsp_busy_ff    <= hold_ff | (phase_ff != PH_IDLE) | (used != '0);
         rsp_free_ff    <= free_ext[2:0];
         rsp_phase_ff   <= phase_ff;
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_pwm_enable    = rsp_pwm_ff;
   assign rsp_reload_value  = rsp_reload_ff;
   assign rsp_compare_value = rsp_compare_ff;
   assign rsp_busy_res      = rsp_busy_ff;
   assign rsp_queue_free    = rsp_free_ff;
   assign rsp_phase         = rsp_phase_ff;

endmodule

`default_nettype wire

FILE: hdl/tps_ram.sv
// ----------------------------------------------------------------------------
// tps_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/tps_div.sv
// ----------------------------------------------------------------------------
// tps_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_div #(
   parameter int DIVIDEND_W = 27,
   parameter int DIVISOR_W  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output      logic                  done,
   output      logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;

   logic [DIVISOR_W:0] trial;
   logic [DIVISOR_W:0] diff;
   logic               ge;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign ge    = (trial >= {1'b0, dsr_ff});
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: hdl/tps_tone.sv
// ----------------------------------------------------------------------------
// tps_tone
// Tone setup: clamps frequency and duty, derives PWM reload and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_tone (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire tps_pkg::tone_req_type         req,
   input  wire tps_pkg::tone_cfg_type         cfg,
   output      logic                          done,
   output      logic [tps_pkg::HZ_W-1:0]      reload,
   output      logic [tps_pkg::HZ_W-1:0]      compare
);

   import tps_pkg::*;

   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_DIV1  = 3'd1;
   localparam logic [2:0] T_MUL   = 3'd2;
   localparam logic [2:0] T_DIVGO = 3'd3;
   localparam logic [2:0] T_DIV2  = 3'd4;

   localparam int MCNT_W = $clog2(DUTY_W);

   logic [2:0]        st_ff, st_in;
   logic              done_ff, done_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [HZ_W-1:0]   rel_ff, rel_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [DUTY_W-1:0] mplier_ff, mplier_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [MCNT_W-1:0] cnt_ff, cnt_in;
   logic [HZ_W-1:0]   reload_ff, reload_in;
   logic [HZ_W-1:0]   compare_ff, compare_in;

   logic              div_start;
   logic [CLK_W-1:0]  div_dividend;
   logic [HZ_W-1:0]   div_divisor;
   logic              div_done;
   logic [CLK_W-1:0]  div_quot;

   logic [HZ_W-1:0]   hz_c;
   logic [DUTY_W-1:0] duty_c;
   logic [CLK_W-1:0]  q_m1;
   logic [HZ_W-1:0]   rel_calc;
   logic [PER_W-1:0]  period_calc;
   logic [PER_W-1:0]  period;
   logic [PER_W-1:0]  cmp0;
   logic [PER_W-1:0]  cmp1;

   tps_div #(
      .DIVIDEND_W (CLK_W),
      .DIVISOR_W  (HZ_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      if (req.hz < cfg.min_hz) begin
         hz_c = cfg.min_hz;
      end else if (req.hz > cfg.max_hz) begin
         hz_c = cfg.max_hz;
      end else begin
         hz_c = req.hz;
      end
      if (req.duty < DUTY_MIN) begin
         duty_c = DUTY_MIN;
      end else if (req.duty > DUTY_MAX) begin
         duty_c = DUTY_MAX;
      end else begin
         duty_c = req.duty;
      end
   end

   // quotient of zero behaves as one: reload zero
   assign q_m1        = div_quot - 1'b1;
   assign rel_calc    = (div_quot == '0)        ? '0 :
                        (|q_m1[CLK_W-1:HZ_W])   ? RELOAD_MAX : q_m1[HZ_W-1:0];
   assign period_calc = {1'b0, rel_calc} + 1'b1;
   assign period      = {1'b0, rel_ff} + 1'b1;
   assign cmp0        = div_quot[PER_W-1:0];
   assign cmp1        = (cmp0 == '0) ? PER_W'(1) : cmp0;

   always_comb begin
      st_in        = st_ff;
      done_in      = 1'b0;
      duty_in      = duty_ff;
      rel_in       = rel_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      reload_in    = reload_ff;
      compare_in   = compare_ff;
      div_start    = 1'b0;
      div_dividend = cfg.clk_hz;
      div_divisor  = hz_c;
      unique case (st_ff)
         T_IDLE: begin
            if (start) begin
               duty_in = duty_c;
               if (hz_c == '0) begin
                  // zero frequency saturates the period
                  rel_in    = RELOAD_MAX;
                  mcand_in  = PROD_W'({1'b0, RELOAD_MAX} + 1'b1);
                  mplier_in = duty_c;
                  prod_in   = '0;
                  cnt_in    = '0;
                  st_in     = T_MUL;
               end else begin
                  div_start = 1'b1;
                  st_in     = T_DIV1;
               end
            end
         end
         T_DIV1: begin
            if (div_done) begin
               rel_in    = rel_calc;
               mcand_in  = PROD_W'(period_calc);
               mplier_in = duty_ff;
               prod_in   = '0;
               cnt_in    = '0;
               st_in     = T_MUL;
            end
         end
         T_MUL: begin
            // shift-add, one duty bit per cycle
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[DUTY_W-1:1]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == MCNT_W'(DUTY_W - 1)) begin
               st_in = T_DIVGO;
            end
         end
         T_DIVGO: begin
            div_start    = 1'b1;
            div_dividend = CLK_W'(prod_ff);
            div_divisor  = PCT_DIV;
            st_in        = T_DIV2;
         end
         T_DIV2: begin
            if (div_done) begin
               reload_in  = rel_ff;
               compare_in = (cmp1 >= period) ? rel_ff : cmp1[HZ_W-1:0];
               done_in    = 1'b1;
               st_in      = T_IDLE;
            end
         end
         default: begin
            st_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= T_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      duty_ff    <= duty_in;
      rel_ff     <= rel_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      prod_ff    <= prod_in;
      cnt_ff     <= cnt_in;
      reload_ff  <= reload_in;
      compare_ff <= compare_in;
   end

   assign done    = done_ff;
   assign reload  = reload_ff;
   assign compare = compare_ff;

endmodule

`default_nettype wire

FILE: tb/tone_pattern_sequencer_top_test.sv
// ----------------------------------------------------------------------------
// tone_pattern_sequencer_top_test
// Self-checking bench for the buzzer tone sequencer. A queue of command words
// feeds a valid/ready driver. Each accepted word is run through a cycle-free
// copy of the sequencer: pattern ring, 1 ms phase machine, hold mode and
// reload/compare setup. The result is queued as the status word the block
// owes. A monitor with random back-pressure checks every status word field by
// field. The run steps through several frequency limit and timer clock
// settings, and the extremes are among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tone_pattern_sequencer_top_test;
   import tps_pkg::*;

   localparam int QDEPTH = 8;
   // the 3-bit operation field has two codes the block must ignore
   localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [HZ_W-1:0]   hz;
      logic [MS_W-1:0]   on_ms;
      logic [MS_W-1:0]   off_ms;
      logic [REP_W-1:0]  rep;
      logic [DUTY_W-1:0] duty;
   } cmd_word_type;

   typedef struct packed {
      logic            accepted;
      logic            pwm_enable;
      logic [HZ_W-1:0] reload;
      logic [HZ_W-1:0] compare;
      logic            busy;
      logic [2:0]      qfree;
      logic [PH_W-1:0] phase;
   } status_word_type;

   // ---------------------------------------------------------------- DUT I/O
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   wire logic            req_ready;
   logic [OP_W-1:0]      req_operation = '0;
   logic [HZ_W-1:0]      req_tone_hz = '0;
   logic [MS_W-1:0]      req_on_time_ms = '0;
   logic [MS_W-1:0]      req_off_time_ms = '0;
   logic [REP_W-1:0]     req_repeat_count = '0;
   logic [DUTY_W-1:0]    req_duty_percent = '0;
   wire logic            rsp_valid;
   logic                 rsp_ready = 1'b0;
   wire logic            rsp_accepted;
   wire logic            rsp_pwm_enable;
   wire logic [HZ_W-1:0] rsp_reload_value;
   wire logic [HZ_W-1:0] rsp_compare_value;
   wire logic            rsp_busy_res;
   wire logic [2:0]      rsp_queue_free;
   wire logic [PH_W-1:0] rsp_phase;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CLK_W-1:0]     csr_wdata = '0;

   tone_pattern_sequencer_top #(.QUEUE_DEPTH(QDEPTH)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_tone_hz       (req_tone_hz),
      .req_on_time_ms    (req_on_time_ms),
      .req_off_time_ms   (req_off_time_ms),
      .req_repeat_count  (req_repeat_count),
      .req_duty_percent  (req_duty_percent),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_pwm_enable    (rsp_pwm_enable),
      .rsp_reload_value  (rsp_reload_value),
      .rsp_compare_value (rsp_compare_value),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_queue_free    (rsp_queue_free),
      .rsp_phase         (rsp_phase),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------ bench bookkeeping
   cmd_word_type    cmd_backlog[$];   // words waiting for the driver
   status_word_type status_due[$];    // status words the block still owes
   cmd_word_type    held_word = '0;   // word currently on the request port
   int              gap_left = 0;
   int              stall_left = 0;
   bit              calm = 1'b0;      // no idling on either side when set
   int              fail_count = 0;
   int              status_count = 0;
   int              turned_away = 0;
   int              setting_count = 1;

   // ------------------------------------------------- sequencer shadow state
   logic [HZ_W-1:0]   cfg_min_hz = MIN_HZ_RST;
   logic [HZ_W-1:0]   cfg_max_hz = MAX_HZ_RST;
   logic [CLK_W-1:0]  cfg_clk_hz = CLK_HZ_RST;
   pattern_type       ring_slot[QDEPTH];
   int                ring_wr = 0;
   int                ring_rd = 0;
   logic [PH_W-1:0]   mach_phase = PH_IDLE;
   logic [MS_W-1:0]   ms_left = '0;
   pattern_type       playing = '0;
   logic              hold_on = 1'b0;
   logic              pwm_on = 1'b0;
   logic [HZ_W-1:0]   reload_now = '0;
   logic [HZ_W-1:0]   compare_now = '0;

   function automatic int ring_fill();
      return (ring_wr - ring_rd + QDEPTH) % QDEPTH;
   endfunction

   // clamp frequency and duty, derive PWM period and high time
   function automatic void start_tone(logic [HZ_W-1:0] hz_in, logic [DUTY_W-1:0] duty_in);
      logic [31:0] hz, duty, quot, rel, period, cmp;
      hz = hz_in;
      duty = duty_in;
      if (hz < cfg_min_hz) hz = cfg_min_hz;
      else if (hz > cfg_max_hz) hz = cfg_max_hz;
      if (duty < DUTY_MIN) duty = DUTY_MIN;
      if (duty > DUTY_MAX) duty = DUTY_MAX;
      if (hz == 0) begin
         rel = RELOAD_MAX;  // zero frequency saturates the reload
      end else begin
         quot = cfg_clk_hz / hz;
         if (quot == 0) quot = 1;
         rel = quot - 1;
         if (rel > RELOAD_MAX) rel = RELOAD_MAX;
      end
      period = rel + 1;
      cmp = (period * duty) / PCT_DIV;
      if (cmp == 0) cmp = 1;
      if (cmp >= period) cmp = period - 1;
      reload_now = rel[HZ_W-1:0];
      compare_now = cmp[HZ_W-1:0];
      pwm_on = 1'b1;
   endfunction

   function automatic void next_repetition();
      if (playing.rep_count != 0) playing.rep_count--;
      if (playing.rep_count != 0) begin
         start_tone(playing.hz, playing.duty);
         ms_left = playing.on_ms;
         mach_phase = PH_ON;
      end else begin
         mach_phase = PH_IDLE;
      end
   endfunction

   function automatic void ms_tick();
      if (!hold_on) begin
         case (mach_phase)
            PH_IDLE: begin
               if (ring_fill() == 0) begin
                  pwm_on = 1'b0;
               end else begin
                  playing = ring_slot[ring_rd];
                  ring_rd = (ring_rd + 1) % QDEPTH;
                  start_tone(playing.hz, playing.duty);
                  ms_left = playing.on_ms;
                  mach_phase = PH_ON;
               end
            end
            PH_ON: begin
               if (ms_left != 0) ms_left--;
               if (ms_left == 0) begin
                  pwm_on = 1'b0;
                  ms_left = playing.off_ms;
                  mach_phase = PH_OFF;
                  if (ms_left == 0) next_repetition();
               end
            end
            default: begin
               if (ms_left != 0) ms_left--;
               if (ms_left == 0) next_repetition();
            end
         endcase
      end
   endfunction

   function automatic logic ring_push(pattern_type ent);
      if ((ring_wr + 1) % QDEPTH == ring_rd) return 1'b0;
      ring_slot[ring_wr] = ent;
      ring_wr = (ring_wr + 1) % QDEPTH;
      return 1'b1;
   endfunction

   // apply one accepted word to the shadow state, queue the status it yields
   function automatic void sequencer_step(cmd_word_type w);
      pattern_type     ent;
      logic            acc;
      status_word_type s;
      acc = 1'b1;
      ent.hz = w.hz;
      ent.on_ms = w.on_ms;
      ent.off_ms = w.off_ms;
      ent.rep_count = w.rep;
      ent.duty = w.duty;
      case (w.op)
         OP_TICK: ms_tick();
         OP_PATTERN: if (w.rep != 0) acc = ring_push(ent);
         OP_ONCE: begin
            if (w.on_ms != 0) begin
               ent.off_ms = '0;
               ent.rep_count = 1;
               acc = ring_push(ent);
            end
         end
         OP_HOLD_START: begin
            start_tone(w.hz, w.duty);
            hold_on = 1'b1;
         end
         OP_HOLD_STOP: begin
            hold_on = 1'b0;
            pwm_on = 1'b0;
         end
         OP_STOP_ALL: begin
            mach_phase = PH_IDLE;
            ms_left = '0;
            ring_wr = 0;
            ring_rd = 0;
            hold_on = 1'b0;
            pwm_on = 1'b0;
         end
         default: ;
      endcase
      if (!acc) turned_away++;
      s.accepted = acc;
      s.pwm_enable = pwm_on;
      s.reload = reload_now;
      s.compare = compare_now;
      s.busy = hold_on || (mach_phase != PH_IDLE) || (ring_fill() != 0);
      s.qfree = 3'(QDEPTH - 1 - ring_fill());
      s.phase = mach_phase;
      status_due.push_back(s);
   endfunction

   // ------------------------------------------------------------ driver side
   // One new word may go out when the port is empty or the current word is
   // taken at this edge. Idle gaps of random length come in unless calm is set.
   always @(posedge clock) begin : drive
      logic launch;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         launch = req_valid;
         if (req_valid && req_ready) begin
            sequencer_step(held_word);
            launch = 1'b0;
         end
         if (!launch) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (!calm && cmd_backlog.size() != 0 && $urandom_range(0, 9) == 0) begin
               gap_left = $urandom_range(0, 4);
            end else if (cmd_backlog.size() != 0) begin
               held_word = cmd_backlog.pop_front();
               launch = 1'b1;
            end
         end
         req_valid <= launch;
         req_operation <= held_word.op;
         req_tone_hz <= held_word.hz;
         req_on_time_ms <= held_word.on_ms;
         req_off_time_ms <= held_word.off_ms;
         req_repeat_count <= held_word.rep;
         req_duty_percent <= held_word.duty;
      end
   end

   // ----------------------------------------------------------- monitor side
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      status_word_type want;
      logic            rdy;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               $error("status word arrived with none outstanding");
               fail_count++;
            end else begin
               want = status_due.pop_front();
               status_count++;
               check_field("accepted", want.accepted, rsp_accepted);
               check_field("pwm_enable", want.pwm_enable, rsp_pwm_enable);
               check_field("reload_value", want.reload, rsp_reload_value);
               check_field("compare_value", want.compare, rsp_compare_value);
               check_field("busy_res", want.busy, rsp_busy_res);
               check_field("queue_free", want.qfree, rsp_queue_free);
               check_field("phase", want.phase, rsp_phase);
            end
         end
         // back-pressure bursts of random length
         if (stall_left != 0) begin
            stall_left--;
            rdy = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 4);
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_ready <= rdy;
      end
   end

   // -------------------------------------------------------- stimulus source
   function automatic void push_cmd(logic [OP_W-1:0] op, logic [HZ_W-1:0] hz,
                                    logic [MS_W-1:0] on_ms, logic [MS_W-1:0] off_ms,
                                    logic [REP_W-1:0] rep, logic [DUTY_W-1:0] duty);
      cmd_word_type w;
      w.op = op;
      w.hz = hz;
      w.on_ms = on_ms;
      w.off_ms = off_ms;
      w.rep = rep;
      w.duty = duty;
      cmd_backlog.push_back(w);
   endfunction

   // frequency mix: zero, very low, audible band, anything
   function automatic logic [HZ_W-1:0] pick_hz();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return '0;
      if (sel == 1) return HZ_W'($urandom_range(1, 20));
      if (sel <= 4) return HZ_W'($urandom_range(50, 12000));
      return HZ_W'($urandom);
   endfunction

   // Mostly ticks and short patterns so the phase machine keeps cycling and
   // the ring fills up; the rest is hold traffic, flushes and odd words.
   task automatic add_random(int count);
      int sel;
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < 63)
            push_cmd(OP_TICK, HZ_W'($urandom), MS_W'($urandom), MS_W'($urandom),
                     REP_W'($urandom), DUTY_W'($urandom));
         else if (sel < 75)
            push_cmd(OP_PATTERN, pick_hz(), MS_W'($urandom_range(0, 3)),
                     MS_W'($urandom_range(0, 2)), REP_W'($urandom_range(1, 2)),
                     DUTY_W'($urandom_range(0, 127)));
         else if (sel < 81)
            push_cmd(OP_ONCE, pick_hz(), MS_W'($urandom_range(1, 3)), MS_W'($urandom),
                     REP_W'($urandom), DUTY_W'($urandom_range(0, 127)));
         else if (sel < 85)
            push_cmd(OP_HOLD_START, pick_hz(), MS_W'($urandom), MS_W'($urandom),
                     REP_W'($urandom), DUTY_W'($urandom_range(0, 127)));
         else if (sel < 89)
            push_cmd(OP_HOLD_STOP, HZ_W'($urandom), MS_W'($urandom), MS_W'($urandom),
                     REP_W'($urandom), DUTY_W'($urandom));
         else if (sel < 92)
            push_cmd(OP_STOP_ALL, HZ_W'($urandom), MS_W'($urandom), MS_W'($urandom),
                     REP_W'($urandom), DUTY_W'($urandom));
         else if (sel < 95)
            // long pattern: clogs the machine until the next flush
            push_cmd(($urandom_range(0, 1) != 0) ? OP_PATTERN : OP_ONCE, HZ_W'($urandom),
                     MS_W'($urandom), MS_W'($urandom), REP_W'($urandom), DUTY_W'($urandom));
         else if (sel < 97)
            push_cmd(($urandom_range(0, 1) != 0) ? OP_RSVD_6 : OP_RSVD_7, HZ_W'($urandom),
                     MS_W'($urandom), MS_W'($urandom), REP_W'($urandom), DUTY_W'($urandom));
         else if (sel < 98)
            push_cmd(OP_PATTERN, pick_hz(), MS_W'($urandom), MS_W'($urandom), '0,
                     DUTY_W'($urandom));
         else
            push_cmd(OP_ONCE, pick_hz(), '0, MS_W'($urandom), REP_W'($urandom),
                     DUTY_W'($urandom));
      end
   endtask

   // wait until every word is in and every status word is back, then let
   // the block wind down before touching its registers
   task automatic drain_and_settle();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_valid || status_due.size() != 0);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CLK_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MIN_HZ: cfg_min_hz = val[HZ_W-1:0];
         CSR_MAX_HZ: cfg_max_hz = val[HZ_W-1:0];
         CSR_CLK_HZ: cfg_clk_hz = val;
         default: ;
      endcase
   endtask

   task automatic new_setting(logic [HZ_W-1:0] lo, logic [HZ_W-1:0] hi, logic [CLK_W-1:0] clk);
      drain_and_settle();
      write_reg(CSR_MIN_HZ, CLK_W'(lo));
      write_reg(CSR_MAX_HZ, CLK_W'(hi));
      write_reg(CSR_CLK_HZ, clk);
      @(posedge clock);
      csr_write_en <= 1'b0;
      setting_count++;
   endtask

   initial begin : run
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed opening with reset limits (100..10000 Hz, 1 MHz timer)
      push_cmd(OP_TICK, '0, '0, '0, '0, '0);                     // tick on empty ring
      push_cmd(OP_HOLD_START, '0, '0, '0, '0, '0);               // raised to min, duty 1
      push_cmd(OP_HOLD_START, '1, '1, '1, '1, 7'd127);           // lowered to max, duty 99
      push_cmd(OP_TICK, '0, '0, '0, '0, '0);                     // frozen by hold
      push_cmd(OP_HOLD_STOP, '0, '0, '0, '0, '0);
      push_cmd(OP_ONCE, 16'd440, '0, '0, 8'd1, 7'd50);           // zero on time: ignored
      push_cmd(OP_PATTERN, 16'd440, 16'd2, 16'd2, '0, 7'd50);    // zero repeat: ignored
      push_cmd(OP_PATTERN, 16'd440, '0, '0, 8'd2, 7'd100);       // one-tick on, no gap
      push_cmd(OP_ONCE, 16'd1000, 16'd1, 16'd9, 8'd9, 7'd0);
      push_cmd(OP_TICK, '0, '0, '0, '0, '0);
      push_cmd(OP_TICK, '0, '0, '0, '0, '0);
      push_cmd(OP_TICK, '0, '0, '0, '0, '0);
      push_cmd(OP_RSVD_6, '1, '1, '1, '1, '1);
      push_cmd(OP_RSVD_7, '0, '0, '0, '0, '0);
      // fill the ring to seven entries; two patterns and the single tone bounce
      repeat (8) push_cmd(OP_PATTERN, 16'd2000, '1, '1, '1, 7'd1);
      push_cmd(OP_ONCE, 16'd3000, 16'd5, '0, '0, 7'd99);
      push_cmd(OP_TICK, '0, '0, '0, '0, '0);
      push_cmd(OP_STOP_ALL, '0, '0, '0, '0, '0);
      add_random(150);

      // widest limits, fastest timer: reload saturates on low tones
      new_setting(16'd1, 16'hFFFF, 27'd100000000);
      add_random(130);

      // zero lower limit with a 1 Hz timer: zero-frequency saturation
      new_setting(16'd0, 16'hFFFF, 27'd1);
      add_random(120);

      // crossed limits and a stopped timer
      new_setting(16'hFFFF, 16'd1, 27'd0);
      add_random(120);

      // ordinary setting, run flat out with no idling at all
      new_setting(16'd300, 16'd3000, 27'd48000000);
      calm = 1'b1;
      add_random(130);
      drain_and_settle();

      if (status_due.size() != 0) begin
         $error("%0d status words never arrived", status_due.size());
         fail_count++;
      end
      $display("Checked %0d status words under %0d limit/timer settings,",
               status_count, setting_count);
      $display("including %0d enqueues refused on a full ring.", turned_away);
      if (fail_count == 0)
         $display("tone_pattern_sequencer_top_test: PASS");
      else
         $display("tone_pattern_sequencer_top_test: FAIL");
      $finish;
   end

   // watchdog: a correct run needs well under a tenth of this
   initial begin : watchdog
      #(10_000_000);
      $display("Timed out with %0d words queued, %0d status words owed",
               cmd_backlog.size(), status_due.size());
      $display("tone_pattern_sequencer_top_test: FAIL");
      $finish;
   end

endmodule

FILE: files.f
hdl/tps_pkg.sv
hdl/tps_ram.sv
hdl/tps_div.sv
hdl/tps_tone.sv
hdl/tone_pattern_sequencer_top.sv
tb/tone_pattern_sequencer_top_test.sv
